>>> rtl/core/dptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptc_pkg
// Types and constants shared by the decimal price to cents parser modules.
// ----------------------------------------------------------------------------
package dptc_pkg;

    // Width of the parsed price in hundredths.
    localparam int PRICE_BITS = 40;

    // Depth of the queue between the classifier and the accumulator.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [1:0] KIND_MARKET = 2'd0;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_MALFORMED    = 3'd1,
        ST_DECIMALS     = 3'd2,
        ST_NOT_POSITIVE = 3'd3,
        ST_OVERFLOW     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CC_NONE  = 2'd0,
        CC_DIGIT = 2'd1,
        CC_DOT   = 2'd2,
        CC_OTHER = 2'd3
    } t_char_class;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
        logic [1:0] order_kind;
    } t_in_item;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price_cents;
        t_status               status;
    } t_out_item;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
        logic        last;
        logic        market;
    } t_cls_item;

endpackage

>>> rtl/core/decimal_price_to_cents_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_price_to_cents_parser_unit
// Parses an ASCII price string, one character per item, into hundredths.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the digit
// accumulator takes one character from the queue each cycle unless the output stalls.
// Path of the result: the last character goes through the queue write, the accumulate
// stage and the scale-and-check stage into the output register.
// Reset: synchronous, active low; clears the queue, the accumulators and all
// valid flags. No clearing pass is needed.
module decimal_price_to_cents_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dptc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dptc_pkg::t_out_item o_data
);
    import dptc_pkg::*;

    logic      w_push;
    t_cls_item w_push_item;
    logic      w_q_not_full;
    logic      w_q_valid;
    logic      w_q_pop;
    t_cls_item w_q_item;

    dptc_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .o_push        (w_push),
        .o_item        (w_push_item),
        .i_queue_ready (w_q_not_full)
    );

    dptc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_push_item),
        .o_not_full (w_q_not_full),
        .o_valid    (w_q_valid),
        .i_pop      (w_q_pop),
        .o_item     (w_q_item)
    );

    dptc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    // Any result other than ok carries a zero price.
    a_err_zero_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_OK) |-> (o_data.price_cents == '0))
        else $error("error result carries a nonzero price");

    // No result appears in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The queue only accepts a character when it has room.
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_not_full)
        else $error("queue written while full");

    // A status code outside the defined set is never produced.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == ST_OK || o_data.status == ST_MALFORMED
                     || o_data.status == ST_DECIMALS
                     || o_data.status == ST_NOT_POSITIVE
                     || o_data.status == ST_OVERFLOW))
        else $error("undefined status code");

endmodule

>>> rtl/core/dptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptc_front
// Classifies each incoming character as digit, dot, other or none and
// drops items that carry no character and do not end the string.
// ----------------------------------------------------------------------------
module dptc_front (
    input  logic                i_valid,
    output logic                o_ready,
    input  dptc_pkg::t_in_item  i_data,
    output logic                o_push,
    output dptc_pkg::t_cls_item o_item,
    input  logic                i_queue_ready
);
    import dptc_pkg::*;

    logic [7:0] w_digit_full;

    assign w_digit_full = i_data.char_code - CHAR_ZERO;

    always_comb begin
        o_item.digit  = w_digit_full[3:0];
        o_item.last   = i_data.last;
        o_item.market = (i_data.order_kind == KIND_MARKET);
        if (!i_data.has_char) begin
            o_item.cls = CC_NONE;
        end else if (i_data.char_code == CHAR_DOT) begin
            o_item.cls = CC_DOT;
        end else if (i_data.char_code >= CHAR_ZERO && i_data.char_code <= CHAR_NINE) begin
            o_item.cls = CC_DIGIT;
        end else begin
            o_item.cls = CC_OTHER;
        end
    end

    // An item with no character that does not end the string changes nothing.
    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready && (i_data.has_char || i_data.last);

endmodule

>>> rtl/core/dptc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptc_queue
// Short first-in first-out queue of classified characters between the
// front and the back.
// ----------------------------------------------------------------------------
module dptc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dptc_pkg::t_cls_item i_item,
    output logic                o_not_full,
    output logic                o_valid,
    input  logic                i_pop,
    output dptc_pkg::t_cls_item o_item
);
    import dptc_pkg::*;

    t_cls_item           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                w_pop;

    assign o_not_full = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_item     = r_mem[r_rptr];
    assign w_pop      = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

>>> rtl/core/dptc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptc_back
// Accumulates the whole and fractional parts one character per cycle unless the
// output stalls, then in a second stage scales by one hundred, checks the range
// and forms the result item in the output register.
// ----------------------------------------------------------------------------
module dptc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  dptc_pkg::t_cls_item  i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dptc_pkg::t_out_item  o_data
);
    import dptc_pkg::*;

    localparam int WW = PRICE_BITS + 4;
    localparam int TW = PRICE_BITS + 7;

    typedef struct packed {
        logic [PRICE_BITS-1:0] whole;
        logic [6:0]            frac;
        logic [1:0]            frac_count;
        logic                  dot_seen;
        logic                  whole_digit_seen;
        logic                  whole_ovf;
        t_status               first_error;
        logic                  market;
    } t_fin_rec;

    // Accumulation state
    logic [PRICE_BITS-1:0] r_whole, n_whole;
    logic [6:0]            r_frac, n_frac;
    logic [1:0]            r_frac_count, n_frac_count;
    logic                  r_dot_seen, n_dot_seen;
    logic                  r_wds, n_wds;
    logic                  r_whole_ovf, n_whole_ovf;
    t_status               r_first_error, n_first_error;

    // Finish stage and output register
    logic                  r_fin_valid, n_fin_valid;
    t_fin_rec              r_fin, n_fin;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  w_out_free, w_fin_adv, w_take;
    logic [WW-1:0]         w_whole_x10;
    logic [6:0]            w_frac_scaled;
    logic [TW-1:0]         w_total;
    logic                  w_too_big;
    t_out_item             w_result;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_fin_adv  = r_fin_valid && w_out_free;
    assign o_q_pop    = !r_fin_valid || w_out_free;
    assign w_take     = i_q_valid && o_q_pop;

    assign w_whole_x10 = {1'b0, r_whole, 3'b000} + {3'b000, r_whole, 1'b0}
                       + {{(WW-4){1'b0}}, i_q_item.digit};

    always_comb begin
        n_whole       = r_whole;
        n_frac        = r_frac;
        n_frac_count  = r_frac_count;
        n_dot_seen    = r_dot_seen;
        n_wds         = r_wds;
        n_whole_ovf   = r_whole_ovf;
        n_first_error = r_first_error;
        n_fin_valid   = r_fin_valid && !w_fin_adv;
        n_fin         = r_fin;

        if (w_take && r_first_error == ST_OK) begin
            unique case (i_q_item.cls)
                CC_NONE: begin
                end
                CC_DOT: begin
                    if (r_dot_seen) begin
                        n_first_error = ST_MALFORMED;
                    end else begin
                        n_dot_seen = 1'b1;
                    end
                end
                CC_OTHER: begin
                    n_first_error = ST_MALFORMED;
                end
                CC_DIGIT: begin
                    if (!r_dot_seen) begin
                        n_wds = 1'b1;
                        // A digit that would carry past the price width is lost.
                        if (r_whole_ovf || (w_whole_x10[WW-1:PRICE_BITS] != '0)) begin
                            n_whole_ovf = 1'b1;
                        end else begin
                            n_whole = w_whole_x10[PRICE_BITS-1:0];
                        end
                    end else if (r_frac_count == 2'd2 || r_frac_count == 2'd3) begin
                        n_first_error = ST_DECIMALS;
                    end else begin
                        n_frac       = 7'({r_frac, 3'b000} + {2'b00, r_frac, 1'b0})
                                     + {3'b000, i_q_item.digit};
                        n_frac_count = r_frac_count + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_take && i_q_item.last) begin
            n_fin_valid          = 1'b1;
            n_fin.whole          = n_whole;
            n_fin.frac           = n_frac;
            n_fin.frac_count     = n_frac_count;
            n_fin.dot_seen       = n_dot_seen;
            n_fin.whole_digit_seen = n_wds;
            n_fin.whole_ovf      = n_whole_ovf;
            n_fin.first_error    = n_first_error;
            n_fin.market         = i_q_item.market;
            n_whole       = '0;
            n_frac        = '0;
            n_frac_count  = '0;
            n_dot_seen    = 1'b0;
            n_wds         = 1'b0;
            n_whole_ovf   = 1'b0;
            n_first_error = ST_OK;
        end
    end

    // Second stage: whole * 100 + scaled fraction, then the status decision.
    always_comb begin
        case (r_fin.frac_count)
            2'd1:    w_frac_scaled = 7'({r_fin.frac, 3'b000} + {2'b00, r_fin.frac, 1'b0});
            2'd2:    w_frac_scaled = r_fin.frac;
            default: w_frac_scaled = '0;
        endcase
    end

    assign w_total = {1'b0, r_fin.whole, 6'b000000}
                   + {2'b00, r_fin.whole, 5'b00000}
                   + {5'b00000, r_fin.whole, 2'b00}
                   + {{(TW-7){1'b0}}, w_frac_scaled};
    assign w_too_big = r_fin.whole_ovf || (w_total[TW-1:PRICE_BITS] != '0);

    always_comb begin
        w_result.price_cents = '0;
        w_result.status      = ST_OK;
        if (r_fin.market) begin
            w_result.status = ST_OK;
        end else if (r_fin.first_error != ST_OK) begin
            w_result.status = r_fin.first_error;
        end else if (!r_fin.whole_digit_seen
                     || (r_fin.dot_seen && r_fin.frac_count == 2'd0)) begin
            w_result.status = ST_MALFORMED;
        end else if (w_too_big) begin
            w_result.status = ST_OVERFLOW;
        end else if (w_total[PRICE_BITS-1:0] == '0) begin
            w_result.status = ST_NOT_POSITIVE;
        end else begin
            w_result.price_cents = w_total[PRICE_BITS-1:0];
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (w_fin_adv) begin
            n_out_valid = 1'b1;
            n_out       = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole       <= '0;
            r_frac        <= '0;
            r_frac_count  <= '0;
            r_dot_seen    <= 1'b0;
            r_wds         <= 1'b0;
            r_whole_ovf   <= 1'b0;
            r_first_error <= ST_OK;
            r_fin_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_whole       <= n_whole;
            r_frac        <= n_frac;
            r_frac_count  <= n_frac_count;
            r_dot_seen    <= n_dot_seen;
            r_wds         <= n_wds;
            r_whole_ovf   <= n_whole_ovf;
            r_first_error <= n_first_error;
            r_fin_valid   <= n_fin_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> sim/dptc_price_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptc_price_checker
// Watches both channels of the price parser. It parses every accepted
// character on its own and compares each result item with the oldest
// expected price and status.
// ----------------------------------------------------------------------------
module dptc_price_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  dptc_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  dptc_pkg::t_out_item i_out_data,
    output int                  o_mismatches,
    output int                  o_pending
);
    import dptc_pkg::*;

    localparam logic [63:0] PRICE_LIMIT = (64'd1 << PRICE_BITS) - 64'd1;
    localparam int          REPORT_MAX  = 10;

    // Parse state of the string that is under way.
    logic [63:0] str_whole;
    int          str_frac;
    int          str_frac_digits;
    bit          str_dot;
    bit          str_has_whole;
    bit          str_whole_lost;
    t_status     str_err;

    t_out_item   prices_due[$];
    int          bad_count;

    task automatic clear_string();
        str_whole       = '0;
        str_frac        = 0;
        str_frac_digits = 0;
        str_dot         = 1'b0;
        str_has_whole   = 1'b0;
        str_whole_lost  = 1'b0;
        str_err         = ST_OK;
    endtask

    task automatic parse_char(input logic [7:0] code);
        logic [63:0] digit;
        digit = {56'd0, code} - {56'd0, CHAR_ZERO};
        // Once an error is latched the rest of the string is ignored.
        if (str_err != ST_OK) begin
            return;
        end
        if (code == CHAR_DOT) begin
            if (str_dot) begin
                str_err = ST_MALFORMED;
            end else begin
                str_dot = 1'b1;
            end
            return;
        end
        if (code < CHAR_ZERO || code > CHAR_NINE) begin
            str_err = ST_MALFORMED;
            return;
        end
        if (!str_dot) begin
            str_has_whole = 1'b1;
            // The whole part freezes once the next digit would not fit.
            if (str_whole_lost || str_whole > (PRICE_LIMIT - digit) / 64'd10) begin
                str_whole_lost = 1'b1;
            end else begin
                str_whole = str_whole * 64'd10 + digit;
            end
        end else if (str_frac_digits >= 2) begin
            str_err = ST_DECIMALS;
        end else begin
            str_frac        = str_frac * 10 + int'(digit);
            str_frac_digits = str_frac_digits + 1;
        end
    endtask

    function automatic t_out_item close_string(input logic [1:0] kind);
        t_out_item   res;
        logic [63:0] frac_cents;
        logic [63:0] total;
        res.price_cents = '0;
        res.status      = ST_OK;
        if (kind == KIND_MARKET) begin
            return res;
        end
        if (str_err != ST_OK) begin
            res.status = str_err;
        end else if (!str_has_whole || (str_dot && str_frac_digits == 0)) begin
            res.status = ST_MALFORMED;
        end else begin
            frac_cents = (str_frac_digits == 1) ? 64'(str_frac) * 64'd10 :
                         (str_frac_digits == 2) ? 64'(str_frac) : 64'd0;
            if (str_whole_lost ||
                str_whole > (PRICE_LIMIT - frac_cents) / 64'd100) begin
                res.status = ST_OVERFLOW;
            end else begin
                total = str_whole * 64'd100 + frac_cents;
                if (total == 64'd0) begin
                    res.status = ST_NOT_POSITIVE;
                end else begin
                    res.price_cents = total[PRICE_BITS-1:0];
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_string();
            prices_due.delete();
            bad_count = 0;
        end else begin
            // Results are checked before new characters are parsed, so a
            // result can never be matched against an item of the same edge.
            if (i_out_valid && i_out_ready) begin
                if (prices_due.size() == 0) begin
                    bad_count = bad_count + 1;
                    if (bad_count <= REPORT_MAX) begin
                        $display("[%0t] unexpected result: price_cents %0d status %0d",
                                 $realtime, i_out_data.price_cents, i_out_data.status);
                    end
                end else begin
                    want = prices_due.pop_front();
                    if (i_out_data.price_cents !== want.price_cents ||
                        i_out_data.status !== want.status) begin
                        bad_count = bad_count + 1;
                        if (bad_count <= REPORT_MAX) begin
                            $display({"[%0t] mismatch: price_cents exp %0d got %0d,",
                                      " status exp %0d got %0d"},
                                     $realtime, want.price_cents, i_out_data.price_cents,
                                     want.status, i_out_data.status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.has_char) begin
                    parse_char(i_in_data.char_code);
                end
                if (i_in_data.last) begin
                    prices_due.push_back(close_string(i_in_data.order_kind));
                    clear_string();
                end
            end
        end
        o_mismatches <= bad_count;
        o_pending    <= prices_due.size();
    end

endmodule

>>> sim/tb_decimal_price_to_cents_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_price_to_cents_parser_unit
// Drives price strings into the parser, first a short set of edge cases and
// then random well-formed, near-limit and broken strings, with random gaps
// on both channels. The checker beside the block decides each result.
// ----------------------------------------------------------------------------
module tb_decimal_price_to_cents_parser_unit;
    import dptc_pkg::*;

    localparam logic [1:0] KIND_LIMIT  = 2'd1;
    localparam logic [1:0] KIND_IOC    = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         ITEM_TARGET = 1750;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         DRAIN_WAIT  = 12;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    int        mismatches;
    int        pending;
    int        items_sent = 0;
    int        idle_cycles = 0;
    bit        steady = 1'b0;
    logic [7:0] price_text[$];

    always #5 i_clk = ~i_clk;

    decimal_price_to_cents_parser_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    dptc_price_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_data  (o_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // Ends a hung run: no item moved on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: a random stall before each item unless in a steady stretch.
    initial begin
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] code, input bit has, input bit fin,
                             input logic [1:0] kind);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{char_code: code, has_char: has, last: fin, order_kind: kind};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent = items_sent + 1;
    endtask

    // Sends price_text as one string. Empty-character items may be mixed in,
    // and the string may close with an item that carries no character.
    task automatic send_price(input logic [1:0] kind, input bit end_empty,
                              input int noise);
        int  i;
        bit  fin;
        for (i = 0; i < price_text.size(); i++) begin
            if (noise > 0 && $urandom_range(0, 99) < noise) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                          2'($urandom_range(0, 3)));
            end
            fin = (i == price_text.size() - 1) && !end_empty;
            send_item(price_text[i], 1'b1, fin, fin ? kind : 2'($urandom_range(0, 3)));
        end
        if (price_text.size() == 0 || end_empty) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, kind);
        end
    endtask

    task automatic load_text(input string s);
        price_text.delete();
        for (int i = 0; i < s.len(); i++) begin
            price_text.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return KIND_MARKET;
        end else if (r < 55) begin
            return KIND_LIMIT;
        end else if (r < 90) begin
            return KIND_IOC;
        end
        return KIND_SPARE;
    endfunction

    task automatic make_wellformed();
        int whole_len;
        int frac_len;
        bit zeros;
        price_text.delete();
        whole_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 13)
                                                : $urandom_range(1, 6);
        frac_len  = $urandom_range(0, 2);
        zeros     = ($urandom_range(0, 19) == 0);
        repeat (whole_len) price_text.push_back(zeros ? CHAR_ZERO : rand_digit());
        if (frac_len > 0) begin
            price_text.push_back(CHAR_DOT);
            repeat (frac_len) price_text.push_back(zeros ? CHAR_ZERO : rand_digit());
        end
    endtask

    // Strings around the largest price that still fits in the result.
    task automatic make_near_limit();
        case ($urandom_range(0, 5))
            0: load_text("10995116277.75");
            1: load_text("10995116277.76");
            2: load_text("10995116277.8");
            3: load_text("1099511627776");
            4: load_text("10995116278");
            default: begin
                load_text("1099511627");
                repeat ($urandom_range(1, 4)) price_text.push_back(rand_digit());
                if ($urandom_range(0, 1) == 1) begin
                    price_text.push_back(CHAR_DOT);
                    repeat ($urandom_range(1, 2)) price_text.push_back(rand_digit());
                end
            end
        endcase
    endtask

    task automatic make_mutant();
        int pos;
        make_wellformed();
        pos = $urandom_range(0, price_text.size() - 1);
        case ($urandom_range(0, 4))
            0: price_text.push_front(CHAR_DOT);
            1: price_text.push_back(CHAR_DOT);
            2: begin
                price_text.delete();
                repeat ($urandom_range(1, 4)) price_text.push_back(rand_digit());
                price_text.push_back(CHAR_DOT);
                repeat ($urandom_range(3, 5)) price_text.push_back(rand_digit());
            end
            3: price_text[pos] = 8'($urandom_range(0, 255));
            default: price_text.insert(pos, CHAR_DOT);
        endcase
    endtask

    task automatic make_junk();
        int r;
        price_text.delete();
        repeat ($urandom_range(0, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                price_text.push_back(rand_digit());
            end else if (r < 75) begin
                price_text.push_back(CHAR_DOT);
            end else begin
                price_text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int strings_done;
        int pick;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edge cases: empty string, market order with a stray byte, leading,
        // trailing and second dot, stray character, decimals after a leading
        // dot, zero, tenths, ignored empty items and a string closed by an
        // item without a character.
        load_text("");
        send_price(KIND_LIMIT, 1'b0, 0);
        price_text.delete();
        price_text.push_back(8'h00);
        send_price(KIND_MARKET, 1'b0, 0);
        load_text(".5");
        send_price(KIND_IOC, 1'b0, 0);
        load_text("5.");
        send_price(KIND_SPARE, 1'b0, 0);
        load_text("1..");
        send_price(KIND_LIMIT, 1'b0, 0);
        load_text("9");
        price_text.push_back(8'hFF);
        send_price(KIND_IOC, 1'b0, 0);
        load_text(".123");
        send_price(KIND_LIMIT, 1'b0, 0);
        load_text("0");
        send_price(KIND_IOC, 1'b0, 0);
        load_text("0.5");
        send_price(KIND_LIMIT, 1'b0, 0);
        load_text("8");
        send_price(KIND_LIMIT, 1'b0, 100);
        load_text("9");
        send_price(KIND_IOC, 1'b1, 0);

        strings_done = 0;
        while (items_sent < ITEM_TARGET) begin
            // Now and then a stretch with no gaps on either side.
            if (strings_done % 80 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                make_wellformed();
            end else if (pick < 70) begin
                make_near_limit();
            end else if (pick < 88) begin
                make_mutant();
            end else begin
                make_junk();
            end
            send_price(pick_kind(), $urandom_range(0, 9) == 0,
                       ($urandom_range(0, 9) == 0) ? 10 : 0);
            strings_done = strings_done + 1;
        end
        i_valid <= 1'b0;
        steady = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
